>>> rtl/core/cms_pkg.sv
// shared types and constants for the min-max contrast stretch block
package cms_pkg;

	localparam logic       OP_MEASURE      = 1'b0;
	localparam logic       OP_STRETCH      = 1'b1;

	localparam int         PIX_W           = 8;
	localparam logic [7:0] FULL_SCALE      = 8'd255;
	localparam logic [7:0] LOW_RESET       = 8'd255;
	localparam logic [7:0] HIGH_RESET      = 8'd0;

	localparam int         CMS_QUEUE_DEPTH = 4;

	// one stretch job handed from the front part to the back part
	typedef struct packed {
		logic             bypass;  // result known without division
		logic             flat;
		logic [PIX_W-1:0] value;   // result when bypass is set
		logic [PIX_W-1:0] num;     // pixel minus minimum
		logic [PIX_W-1:0] den;     // maximum minus minimum
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

endpackage

>>> rtl/core/cms_front.sv
// front part: statistics update and classification of stretch pixels
module cms_front
	import cms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             op,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_start,
	output logic             push,
	output job_t             job
);

	logic [PIX_W-1:0] low_q;
	logic [PIX_W-1:0] high_q;
	logic [PIX_W-1:0] low_base;
	logic [PIX_W-1:0] high_base;

	assign low_base  = frame_start ? LOW_RESET  : low_q;
	assign high_base = frame_start ? HIGH_RESET : high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (take && op == OP_MEASURE) begin
			low_q  <= (pixel < low_base)  ? pixel : low_base;
			high_q <= (pixel > high_base) ? pixel : high_base;
		end
	end

	assign push = take && op == OP_STRETCH;

	always_comb begin
		job.flat   = 1'b0;
		job.bypass = 1'b0;
		job.value  = '0;
		job.num    = pixel - low_q;
		job.den    = high_q - low_q;
		if (high_q <= low_q) begin
			job.flat   = 1'b1;
			job.bypass = 1'b1;
		end else if (pixel <= low_q) begin
			job.bypass = 1'b1;
		end else if (pixel >= high_q) begin
			job.bypass = 1'b1;
			job.value  = FULL_SCALE;
		end
	end

endmodule

>>> rtl/core/cms_queue.sv
// short job queue between the front and back parts
module cms_queue
	import cms_pkg::*;
#(
	parameter int Depth = CMS_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output job_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = count_q == FullCnt;
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/cms_back.sv
// back part: radix-2 divider and result register
module cms_back
	import cms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  job_t             job,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic             flat
);

	localparam int CntW = $clog2(PIX_W);
	localparam logic [CntW-1:0] LastStep = CntW'(PIX_W - 1);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [PIX_W-1:0]  rem_q;
	logic [PIX_W-1:0]  dvd_q;
	logic [PIX_W-1:0]  den_q;
	logic [PIX_W-1:0]  quo_q;
	logic [CntW-1:0]   step_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              flat_q;

	logic              slot_free;
	logic              load_div;
	logic              load_out;
	logic [PIX_W-1:0]  out_value;
	logic              out_flat;
	logic [2*PIX_W-1:0] product;
	logic [PIX_W:0]    trial;
	logic              fits;

	assign slot_free = !out_valid_q || !res_stall;
	// num * 255 as num * 256 - num
	assign product   = {job.num, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, job.num};
	assign trial     = {rem_q, dvd_q[PIX_W-1]};
	assign fits      = trial >= {1'b0, den_q};

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_div  = 1'b0;
		load_out  = 1'b0;
		out_value = quo_q;
		out_flat  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					if (job.bypass) begin
						if (slot_free) begin
							pop       = 1'b1;
							load_out  = 1'b1;
							out_value = job.value;
							out_flat  = job.flat;
						end
					end else begin
						pop      = 1'b1;
						load_div = 1'b1;
						state_d  = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (step_q == LastStep) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (load_div) begin
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			step_q <= step_q + 1'b1;
		end
	end

	// quotient fits in 8 bits, so the upper dividend byte starts below den
	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q <= product[2*PIX_W-1:PIX_W];
			dvd_q <= product[PIX_W-1:0];
			den_q <= job.den;
			quo_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= fits ? PIX_W'(trial - {1'b0, den_q}) : trial[PIX_W-1:0];
			dvd_q <= {dvd_q[PIX_W-2:0], 1'b0};
			quo_q <= {quo_q[PIX_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_out_q <= out_value;
			flat_q      <= out_flat;
		end
	end

	assign res_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign flat      = flat_q;

endmodule

>>> rtl/core/min_max_contrast_stretch.sv
// top level of the min-max contrast stretch block
// Linear min-max contrast stretch of 8-bit pixels in two passes. A measure
// transfer (op 0) widens the running minimum and maximum, and frame_start
// clears them first; it gives no result and ends in the front part. A
// stretch transfer (op 1) is classified in the front part against the
// statistics held at that moment and queued; it gives one result transfer
// of (pixel - min) * 255 / (max - min), truncated, saturated to 0 below the
// minimum and 255 above the maximum, and 0 with flat set when max is not
// above min. Stretch pixels that saturate or are flat go from the queue
// straight into the result register; any other stretch pixel goes through
// the shared radix-2 divider (a load step, eight quotient bits, then a step
// into the result register). The queue of QueueDepth jobs lets measure and
// saturated pixels flow while a division is running; pix_stall rises only
// when the queue is full.
module min_max_contrast_stretch
	import cms_pkg::*;
#(
	parameter int QueueDepth = CMS_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             pix_valid,
	output logic             pix_stall,
	input  logic             op,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_start,
	// result channel
	output logic             res_valid,
	input  logic             res_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic             flat
);

	logic take;
	logic push;
	job_t push_job;
	logic pop;
	logic q_full;
	logic q_nonempty;
	job_t head_job;

	// all transfers wait while the job queue is full so order is kept
	assign pix_stall = q_full;
	assign take      = pix_valid && !pix_stall;

	cms_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.op          (op),
		.pixel       (pixel),
		.frame_start (frame_start),
		.push        (push),
		.job         (push_job)
	);

	cms_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head_job)
	);

	// division and result register
	cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_nonempty),
		.job       (head_job),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_out (pixel_out),
		.flat      (flat)
	);

endmodule
